### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the reservoir point sampler
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rpsamp_pkg.sv
// ----------------------------------------------------------------------------
// rpsamp_pkg
// types and constants shared by the reservoir point sampler modules
// ----------------------------------------------------------------------------
package rpsamp_pkg;

	localparam int DATA_W  = 32;  // coordinate port width
	localparam int COUNT_W = 32;  // point counter width
	localparam int RND_W   = 31;  // random word width
	localparam int CFG_W   = 4;   // configuration register width
	localparam int CIDX_W  = 3;
	localparam int SLOT_W  = 3;
	localparam int REGI_W  = 2;   // configuration index width
	localparam int DIVS_W  = COUNT_W + 1;

	localparam logic [1:0] MODE_SAMPLE  = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [REGI_W-1:0] REG_SLOTS = 2'd0;
	localparam logic [REGI_W-1:0] REG_DIMS  = 2'd1;

	localparam logic [CFG_W-1:0] SLOTS_RST = 4'd8;
	localparam logic [CFG_W-1:0] DIMS_RST  = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MODW,
		ST_WRITE,
		ST_RDATA
	} state_t;

endpackage

### design/rpsamp_ram.sv
// ----------------------------------------------------------------------------
// rpsamp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rpsamp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/rpsamp_mod.sv
// ----------------------------------------------------------------------------
// rpsamp_mod
// bit-serial restoring remainder: one dividend bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpsamp_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rpsamp_pkg::RND_W-1:0]  dividend,
	input  logic [rpsamp_pkg::DIVS_W-1:0] divisor,
	output logic                          done,
	output logic [rpsamp_pkg::RND_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(rpsamp_pkg::RND_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(rpsamp_pkg::RND_W - 1);

	logic                          run_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [rpsamp_pkg::RND_W-1:0]  rem_q;
	logic [rpsamp_pkg::RND_W-1:0]  dvd_q;
	logic [rpsamp_pkg::DIVS_W-1:0] dvs_q;

	logic [rpsamp_pkg::RND_W:0]    shifted;
	logic [rpsamp_pkg::RND_W-1:0]  rem_nx;

	// remainder stays below the divisor, so the shifted value is under twice it
	always_comb begin
		shifted = {rem_q, dvd_q[rpsamp_pkg::RND_W-1]};
		if ({1'b0, shifted} >= dvs_q) begin
			rem_nx = rpsamp_pkg::RND_W'(shifted - dvs_q[rpsamp_pkg::RND_W:0]);
		end else begin
			rem_nx = rpsamp_pkg::RND_W'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == LAST);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[rpsamp_pkg::RND_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

	`RPS_ASSERT(a_rem_below_divisor, done |-> ({2'b00, rem_q} < dvs_q), "remainder not reduced")
	`RPS_ASSERT(a_no_restart, start |-> !run_q, "start while remainder unit running")
	`RPS_ASSERT(a_done_after_last, (run_q && cnt_q == LAST) |=> done, "missing done pulse")

endmodule

### design/reservoir_point_sampler_top.sv
// ----------------------------------------------------------------------------
// reservoir_point_sampler_top
// reservoir sampling of up to K points, one coordinate per transaction
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Sample
// transactions pass through the EXEC and WRITE states before busy falls
// again, restart transactions and those of the unused mode through EXEC
// alone; a read passes through EXEC and RDATA, and its result appears on
// read_coord and points_seen with done high for exactly one cycle, which the
// receiver cannot stall. The first coordinate of a point that arrives once
// K points have been counted also needs random_value mod (count + 1),
// worked out by a bit-serial remainder unit at one bit per cycle, while
// the transaction waits in the MODW state between EXEC and WRITE. The
// sample store is a ram of MAX_SLOTS x MAX_DIMS words with one write and
// one registered read port; it is not cleared after reset, and reading a
// slot that was never filled returns undefined data. Configuration writes
// are always ready and should only be issued while busy is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reservoir_point_sampler_top #(
	parameter int MAX_SLOTS   = 8,
	parameter int MAX_DIMS    = 8,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           mode,
	input  logic signed [rpsamp_pkg::DATA_W-1:0] coord_value,
	input  logic [rpsamp_pkg::CIDX_W-1:0]        coord_index,
	input  logic                                 last_coord,
	input  logic [rpsamp_pkg::RND_W-1:0]         random_value,
	input  logic [rpsamp_pkg::SLOT_W-1:0]        read_slot,
	// results
	output logic                                 done,
	output logic signed [rpsamp_pkg::DATA_W-1:0] read_coord,
	output logic [rpsamp_pkg::COUNT_W-1:0]       points_seen,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rpsamp_pkg::REGI_W-1:0]        cfg_index,
	input  logic [rpsamp_pkg::CFG_W-1:0]         cfg_data
);

	localparam int DEPTH = MAX_SLOTS * MAX_DIMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rpsamp_pkg::state_t state_q, state_nx;

	// configuration and control state
	logic [rpsamp_pkg::CFG_W-1:0]   slots_q;
	logic [rpsamp_pkg::CFG_W-1:0]   dims_q;
	logic [rpsamp_pkg::COUNT_W-1:0] count_q;
	logic [rpsamp_pkg::CFG_W-1:0]   tgt_slot_q;
	logic                           tgt_valid_q;

	// latched transaction
	logic [1:0]                     mode_q;
	logic [rpsamp_pkg::DATA_W-1:0]  coord_q;
	logic [rpsamp_pkg::CIDX_W-1:0]  cidx_q;
	logic                           last_q;
	logic [rpsamp_pkg::RND_W-1:0]   rnd_q;
	logic [rpsamp_pkg::SLOT_W-1:0]  rslot_q;
	logic                           rd_ok_q;

	logic [rpsamp_pkg::CFG_W-1:0]   slots_eff;
	logic [rpsamp_pkg::CFG_W-1:0]   dims_eff;
	logic                           accept;
	logic                           first_coord;
	logic                           filling;
	logic                           rd_ok;
	logic                           div_start;
	logic                           div_done;
	logic [rpsamp_pkg::RND_W-1:0]   div_rem;
	logic                           mem_we;
	logic                           mem_re;
	logic [AW-1:0]                  mem_waddr;
	logic [AW-1:0]                  mem_raddr;
	logic [COORD_WIDTH-1:0]         mem_wdata;
	logic [COORD_WIDTH-1:0]         mem_rdata;
	logic signed [COORD_WIDTH-1:0]  rd_s;
	logic [63:0]                    rd_ext;
	logic [63:0]                    coord_ext;

	// registers used clamped to their legal range
	always_comb begin
		priority if (slots_q == '0) begin
			slots_eff = rpsamp_pkg::CFG_W'(1);
		end else if (32'(slots_q) > 32'(MAX_SLOTS)) begin
			slots_eff = rpsamp_pkg::CFG_W'(MAX_SLOTS);
		end else begin
			slots_eff = slots_q;
		end
		priority if (dims_q == '0) begin
			dims_eff = rpsamp_pkg::CFG_W'(1);
		end else if (32'(dims_q) > 32'(MAX_DIMS)) begin
			dims_eff = rpsamp_pkg::CFG_W'(MAX_DIMS);
		end else begin
			dims_eff = dims_q;
		end
	end

	assign accept      = start && !busy;
	assign cfg_ready   = 1'b1;
	assign first_coord = (cidx_q == '0);
	assign filling     = count_q < rpsamp_pkg::COUNT_W'(slots_eff);
	assign rd_ok       = (rpsamp_pkg::CFG_W'(rslot_q) < slots_eff) &&
	                     (rpsamp_pkg::CFG_W'(cidx_q) < dims_eff);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rpsamp_pkg::ST_IDLE: begin
				if (start) state_nx = rpsamp_pkg::ST_EXEC;
			end
			rpsamp_pkg::ST_EXEC: begin
				unique case (mode_q)
					rpsamp_pkg::MODE_SAMPLE: begin
						if (first_coord && !filling) state_nx = rpsamp_pkg::ST_MODW;
						else state_nx = rpsamp_pkg::ST_WRITE;
					end
					rpsamp_pkg::MODE_READ: state_nx = rpsamp_pkg::ST_RDATA;
					default: state_nx = rpsamp_pkg::ST_IDLE;
				endcase
			end
			rpsamp_pkg::ST_MODW: begin
				if (div_done) state_nx = rpsamp_pkg::ST_WRITE;
			end
			rpsamp_pkg::ST_WRITE: state_nx = rpsamp_pkg::ST_IDLE;
			rpsamp_pkg::ST_RDATA: state_nx = rpsamp_pkg::ST_IDLE;
			default: state_nx = rpsamp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy      = (state_q != rpsamp_pkg::ST_IDLE);
		done      = (state_q == rpsamp_pkg::ST_RDATA);
		div_start = (state_q == rpsamp_pkg::ST_EXEC) &&
		            (mode_q == rpsamp_pkg::MODE_SAMPLE) && first_coord && !filling;
		mem_re    = (state_q == rpsamp_pkg::ST_EXEC) &&
		            (mode_q == rpsamp_pkg::MODE_READ) && rd_ok;
		mem_we    = (state_q == rpsamp_pkg::ST_WRITE) && tgt_valid_q &&
		            (tgt_slot_q < slots_eff) &&
		            (rpsamp_pkg::CFG_W'(cidx_q) < dims_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpsamp_pkg::ST_IDLE;
			slots_q     <= rpsamp_pkg::SLOTS_RST;
			dims_q      <= rpsamp_pkg::DIMS_RST;
			count_q     <= '0;
			tgt_slot_q  <= '0;
			tgt_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				unique case (cfg_index)
					rpsamp_pkg::REG_SLOTS: slots_q <= cfg_data;
					rpsamp_pkg::REG_DIMS:  dims_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == rpsamp_pkg::ST_EXEC) begin
				if (mode_q == rpsamp_pkg::MODE_SAMPLE && first_coord && filling) begin
					tgt_slot_q  <= rpsamp_pkg::CFG_W'(count_q);
					tgt_valid_q <= 1'b1;
					count_q     <= count_q + rpsamp_pkg::COUNT_W'(1);
				end
				if (mode_q == rpsamp_pkg::MODE_RESTART) begin
					count_q     <= '0;
					tgt_slot_q  <= '0;
					tgt_valid_q <= 1'b0;
				end
			end
			if (state_q == rpsamp_pkg::ST_MODW && div_done) begin
				// point replaces a random slot, or is dropped
				if (div_rem < rpsamp_pkg::RND_W'(slots_eff)) begin
					tgt_slot_q  <= rpsamp_pkg::CFG_W'(div_rem);
					tgt_valid_q <= 1'b1;
				end else begin
					tgt_valid_q <= 1'b0;
				end
				if (count_q != '1) count_q <= count_q + rpsamp_pkg::COUNT_W'(1);
			end
			if (state_q == rpsamp_pkg::ST_WRITE && last_q) begin
				tgt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			coord_q <= coord_value;
			cidx_q  <= coord_index;
			last_q  <= last_coord;
			rnd_q   <= random_value;
			rslot_q <= read_slot;
		end
		if (state_q == rpsamp_pkg::ST_EXEC) begin
			rd_ok_q <= rd_ok;
		end
	end

	rpsamp_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rnd_q),
		.divisor   ({1'b0, count_q} + rpsamp_pkg::DIVS_W'(1)),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign mem_waddr = AW'(32'(tgt_slot_q) * 32'(MAX_DIMS) + 32'(cidx_q));
	assign mem_raddr = AW'(32'(rslot_q) * 32'(MAX_DIMS) + 32'(cidx_q));
	assign coord_ext = 64'(coord_q);
	assign mem_wdata = coord_ext[COORD_WIDTH-1:0];

	rpsamp_ram #(
		.WIDTH (COORD_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// stored words are sign extended from their stored width
	assign rd_s        = mem_rdata;
	assign rd_ext      = 64'(rd_s);
	assign read_coord  = rd_ok_q ? rd_ext[rpsamp_pkg::DATA_W-1:0] : '0;
	assign points_seen = count_q;

	`RPS_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "accepted transaction not started")
	`RPS_ASSERT(a_done_from_exec, done |-> ($past(state_q) == rpsamp_pkg::ST_EXEC), "stray result")
	`RPS_ASSERT(a_rem_in_wait, div_done |-> (state_q == rpsamp_pkg::ST_MODW), "remainder unexpected")

endmodule
